### sv/dotf_pkg.sv
// Shared types, constants and helpers for the DHCP option tag finder.
`default_nettype none

package dotf_pkg;

  localparam int unsigned MAX_REGION_BYTES_DEF = 312;
  localparam int unsigned OFFSET_W = 9;
  localparam int unsigned LEN_W = 8;
  localparam int unsigned TAG_W = 8;
  localparam int unsigned REGION_W = 2;
  localparam int unsigned COOKIE_CNT_W = 3;

  localparam logic [TAG_W-1:0] TAG_PAD = 8'd0;
  localparam logic [TAG_W-1:0] TAG_OVERLOAD = 8'd52;
  localparam logic [TAG_W-1:0] TAG_END = 8'd255;

  localparam logic [REGION_W-1:0] RGN_COOKIE = 2'd0;
  localparam logic [REGION_W-1:0] RGN_OPTIONS = 2'd1;
  localparam logic [REGION_W-1:0] RGN_FILE = 2'd2;
  localparam logic [REGION_W-1:0] RGN_SNAME = 2'd3;

  localparam logic [COOKIE_CNT_W-1:0] COOKIE_LEN = 3'd4;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

  typedef enum logic [1:0] {
    PH_TAG   = 2'd0,
    PH_LEN   = 2'd1,
    PH_FIRST = 2'd2,
    PH_DATA  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]          data_byte;
    logic [REGION_W-1:0] region;
    logic                last_of_message;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [REGION_W-1:0] found_region;
    logic [OFFSET_W-1:0] data_offset;
    logic [LEN_W-1:0]    data_length;
  } out_item_t;

  // Expected magic cookie byte at a given position.
  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h63;
      2'd1:    b = 8'h82;
      2'd2:    b = 8'h53;
      default: b = 8'h63;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### sv/dotf_parser.sv
// Option TLV walker: per-message parse state and the result of one message.
`default_nettype none

module dotf_parser #(
  parameter int unsigned MAX_REGION_BYTES = dotf_pkg::MAX_REGION_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire dotf_pkg::in_item_t  item,
  input  wire logic [7:0]          search_tag,
  output dotf_pkg::out_item_t      result
);

  localparam logic [dotf_pkg::OFFSET_W-1:0] MAX_OFF =
    dotf_pkg::OFFSET_W'(MAX_REGION_BYTES);

  dotf_pkg::phase_t phase_r, phase_nxt;
  logic [dotf_pkg::OFFSET_W-1:0]     offset_r, offset_nxt;
  logic [dotf_pkg::REGION_W-1:0]     cur_region_r, cur_region_nxt;
  logic [7:0]                        skip_r, skip_nxt;
  logic                              ended_r, ended_nxt;
  logic [dotf_pkg::COOKIE_CNT_W-1:0] cookie_cnt_r, cookie_cnt_nxt;
  logic                              cookie_ok_r, cookie_ok_nxt;
  logic [7:0]                        tag_r, tag_nxt;
  logic [1:0]                        ovl_r, ovl_nxt;
  logic                              mvalid_r, mvalid_nxt;
  logic                              pend_r, pend_nxt;
  logic [dotf_pkg::REGION_W-1:0]     mregion_r, mregion_nxt;
  logic [dotf_pkg::OFFSET_W-1:0]     moff_r, moff_nxt;
  logic [7:0]                        mlen_r, mlen_nxt;

  always_comb begin
    logic [7:0]                    b;
    logic [dotf_pkg::REGION_W-1:0] r;
    logic [dotf_pkg::OFFSET_W-1:0] off;
    logic [7:0]                    skip_dec;
    logic                          enabled;
    logic                          hit;

    b = item.data_byte;
    r = item.region;

    phase_nxt      = phase_r;
    offset_nxt     = offset_r;
    cur_region_nxt = cur_region_r;
    skip_nxt       = skip_r;
    ended_nxt      = ended_r;
    cookie_cnt_nxt = cookie_cnt_r;
    cookie_ok_nxt  = cookie_ok_r;
    tag_nxt        = tag_r;
    ovl_nxt        = ovl_r;
    mvalid_nxt     = mvalid_r;
    pend_nxt       = pend_r;
    mregion_nxt    = mregion_r;
    moff_nxt       = moff_r;
    mlen_nxt       = mlen_r;

    // A new region restarts the walk at offset zero.
    if (r != cur_region_r) begin
      cur_region_nxt = r;
      offset_nxt     = '0;
      phase_nxt      = dotf_pkg::PH_TAG;
      skip_nxt       = '0;
      ended_nxt      = 1'b0;
      pend_nxt       = 1'b0;
    end

    off      = offset_nxt;
    skip_dec = skip_nxt - 8'd1;
    hit      = !mvalid_nxt && (tag_nxt == search_tag);
    enabled  = (r == dotf_pkg::RGN_OPTIONS) ||
               (r == dotf_pkg::RGN_FILE && ovl_nxt[0]) ||
               (r == dotf_pkg::RGN_SNAME && ovl_nxt[1]);

    if (r == dotf_pkg::RGN_COOKIE) begin
      if (cookie_cnt_nxt < dotf_pkg::COOKIE_LEN) begin
        if (b != dotf_pkg::cookie_byte(cookie_cnt_nxt[1:0])) cookie_ok_nxt = 1'b0;
        cookie_cnt_nxt = cookie_cnt_nxt + 3'd1;
      end else begin
        cookie_ok_nxt = 1'b0;
      end
    end else begin
      if (off >= MAX_OFF) begin
        ended_nxt = 1'b1;
        pend_nxt  = 1'b0;
      end
      if (enabled && !ended_nxt) begin
        case (phase_nxt)
          dotf_pkg::PH_TAG: begin
            if (b == dotf_pkg::TAG_END) begin
              ended_nxt = 1'b1;
            end else if (b == dotf_pkg::TAG_PAD) begin
              if (!mvalid_nxt && search_tag == dotf_pkg::TAG_PAD) begin
                mvalid_nxt  = 1'b1;
                mregion_nxt = r;
                moff_nxt    = off + 9'd1;
                mlen_nxt    = '0;
              end
            end else begin
              tag_nxt   = b;
              phase_nxt = dotf_pkg::PH_LEN;
            end
          end
          dotf_pkg::PH_LEN: begin
            if (b == 8'd0) begin
              if (hit) begin
                mvalid_nxt  = 1'b1;
                mregion_nxt = r;
                moff_nxt    = off + 9'd1;
                mlen_nxt    = '0;
              end
              phase_nxt = dotf_pkg::PH_TAG;
            end else begin
              // Hold the candidate until its data is complete.
              if (hit) begin
                pend_nxt = 1'b1;
                moff_nxt = off + 9'd1;
                mlen_nxt = b;
              end
              skip_nxt  = b;
              phase_nxt = dotf_pkg::PH_FIRST;
            end
          end
          default: begin
            if (phase_nxt == dotf_pkg::PH_FIRST && tag_nxt == dotf_pkg::TAG_OVERLOAD &&
                r == dotf_pkg::RGN_OPTIONS)
              ovl_nxt = ovl_nxt | b[1:0];
            skip_nxt = skip_dec;
            if (skip_dec == 8'd0) begin
              if (pend_nxt) begin
                mvalid_nxt  = 1'b1;
                mregion_nxt = r;
                pend_nxt    = 1'b0;
              end
              phase_nxt = dotf_pkg::PH_TAG;
            end else begin
              phase_nxt = dotf_pkg::PH_DATA;
            end
          end
        endcase
      end
    end

    if (offset_nxt != dotf_pkg::OFFSET_MAX) offset_nxt = offset_nxt + 9'd1;

    if (mvalid_nxt && cookie_ok_nxt && cookie_cnt_nxt == dotf_pkg::COOKIE_LEN) begin
      result.found        = 1'b1;
      result.found_region = mregion_nxt - 2'd1;
      result.data_offset  = moff_nxt;
      result.data_length  = mlen_nxt;
    end else begin
      result = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_of_message)) begin
      phase_r      <= dotf_pkg::PH_TAG;
      offset_r     <= '0;
      cur_region_r <= '0;
      skip_r       <= '0;
      ended_r      <= 1'b0;
      cookie_cnt_r <= '0;
      cookie_ok_r  <= 1'b1;
      tag_r        <= '0;
      ovl_r        <= '0;
      mvalid_r     <= 1'b0;
      pend_r       <= 1'b0;
      mregion_r    <= '0;
      moff_r       <= '0;
      mlen_r       <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      offset_r     <= offset_nxt;
      cur_region_r <= cur_region_nxt;
      skip_r       <= skip_nxt;
      ended_r      <= ended_nxt;
      cookie_cnt_r <= cookie_cnt_nxt;
      cookie_ok_r  <= cookie_ok_nxt;
      tag_r        <= tag_nxt;
      ovl_r        <= ovl_nxt;
      mvalid_r     <= mvalid_nxt;
      pend_r       <= pend_nxt;
      mregion_r    <= mregion_nxt;
      moff_r       <= moff_nxt;
      mlen_r       <= mlen_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/dhcp_option_tag_finder.sv
// Top level: DHCP option tag search over a byte stream, one result per message.
// Timing: a byte is registered in the input stage on transfer and parsed from there; the
//   result of a message is loaded into the output register when its last byte is parsed,
//   which waits while that register is full and stalled; out_valid shows the register.
// Throughput: one byte per cycle; the single parse stage stalls only when a last byte
//   finds the output register still full and stalled.
// Reset (rst_n low, synchronous): parse state cleared, search_tag set to 0, no output.
`default_nettype none

module dhcp_option_tag_finder #(
  parameter int unsigned MAX_REGION_BYTES = dotf_pkg::MAX_REGION_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire dotf_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output dotf_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata
);

  logic [7:0]          search_tag_r;
  logic                s1_valid_r;
  dotf_pkg::in_item_t  s1_item_r;
  logic                out_valid_r;
  dotf_pkg::out_item_t out_item_r;
  dotf_pkg::out_item_t result;
  logic                s1_adv;
  logic                emit;
  logic                in_take;

  // A last byte needs room in the output register; other bytes always advance.
  assign s1_adv   = !s1_item_r.last_of_message || !out_valid_r || !out_stall;
  assign emit     = s1_valid_r && s1_adv && s1_item_r.last_of_message;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  dotf_parser #(
    .MAX_REGION_BYTES(MAX_REGION_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_valid_r && s1_adv),
    .item       (s1_item_r),
    .search_tag (search_tag_r),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_tag_r <= '0;
    end else if (cfg_we) begin
      search_tag_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      // Drop the result once its transfer completes.
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_item_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

### tb/sv/dhcp_option_tag_finder_tb.sv
// Self-checking testbench for the DHCP option tag finder: directed and random messages.
module dhcp_option_tag_finder_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [31:0] COOKIE_WORD = 32'h63825363;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  dotf_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  dotf_pkg::out_item_t out_data;
  logic                cfg_we;
  logic [7:0]          cfg_wdata;

  dhcp_option_tag_finder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted parser state and the current search tag.
  logic [7:0]       tag_sel;
  dotf_pkg::phase_t ph;
  logic [8:0]       region_off;
  logic [1:0]       cur_region;
  logic [7:0]       skip_left;
  logic             region_closed;
  logic [2:0]       cookie_seen;
  logic             cookie_good;
  logic [7:0]       opt_tag;
  logic [1:0]       overload_en;
  logic             hit_valid;
  logic             cand_pending;
  logic [1:0]       hit_region;
  logic [8:0]       hit_offset;
  logic [7:0]       hit_length;

  dotf_pkg::out_item_t expected_results[$];
  dotf_pkg::out_item_t want_result;
  dotf_pkg::in_item_t  msg_bytes[$];
  int        bytes_sent;
  int        mismatches;
  int        cycle_count;
  logic      idle_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Receiver back-pressure: short free runs, stalls mostly short and a few long.
  initial begin
    out_stall <= 1'b0;
    forever begin
      if (!idle_on) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b1;
        repeat (1 + pick_gap()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void report_error(input string what, input dotf_pkg::out_item_t want,
                                       input dotf_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%s: expected found=%0d region=%0d offset=%0d length=%0d, ",
                "got found=%0d region=%0d offset=%0d length=%0d"},
               what, want.found, want.found_region, want.data_offset, want.data_length,
               got.found, got.found_region, got.data_offset, got.data_length);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_error("unexpected result", '0, out_data);
      end else begin
        want_result = expected_results.pop_front();
        if (out_data.found !== want_result.found ||
            out_data.found_region !== want_result.found_region ||
            out_data.data_offset !== want_result.data_offset ||
            out_data.data_length !== want_result.data_length)
          report_error("result mismatch", want_result, out_data);
      end
    end
  end

  function automatic void clear_search_state();
    ph = dotf_pkg::PH_TAG;
    region_off = '0;
    cur_region = dotf_pkg::RGN_COOKIE;
    skip_left = '0;
    region_closed = 1'b0;
    cookie_seen = '0;
    cookie_good = 1'b1;
    opt_tag = '0;
    overload_en = '0;
    hit_valid = 1'b0;
    cand_pending = 1'b0;
    hit_region = '0;
    hit_offset = '0;
    hit_length = '0;
  endfunction

  function automatic void take_match(input logic [1:0] r, input logic [8:0] off,
                                     input logic [7:0] len);
    hit_valid = 1'b1;
    hit_region = r;
    hit_offset = off;
    hit_length = len;
  endfunction

  // Advance the predicted parser by one accepted byte; queue a result on the last byte.
  function automatic void track_byte(input dotf_pkg::in_item_t it);
    logic [7:0] b;
    logic [1:0] r;
    logic [8:0] off;
    logic       enabled;
    logic       hit;
    dotf_pkg::out_item_t res;
    b = it.data_byte;
    r = it.region;
    if (r != cur_region) begin
      cur_region = r;
      region_off = '0;
      ph = dotf_pkg::PH_TAG;
      skip_left = '0;
      region_closed = 1'b0;
      cand_pending = 1'b0;
    end
    off = region_off;
    if (r == dotf_pkg::RGN_COOKIE) begin
      if (cookie_seen < dotf_pkg::COOKIE_LEN) begin
        if (b != COOKIE_WORD[31 - 8*cookie_seen -: 8]) cookie_good = 1'b0;
        cookie_seen = cookie_seen + 3'd1;
      end else begin
        cookie_good = 1'b0;
      end
    end else begin
      enabled = (r == dotf_pkg::RGN_OPTIONS) ||
                (r == dotf_pkg::RGN_FILE && overload_en[0]) ||
                (r == dotf_pkg::RGN_SNAME && overload_en[1]);
      if (region_off >= dotf_pkg::MAX_REGION_BYTES_DEF) begin
        region_closed = 1'b1;
        cand_pending = 1'b0;
      end
      if (enabled && !region_closed) begin
        if (ph == dotf_pkg::PH_TAG) begin
          if (b == dotf_pkg::TAG_END) begin
            region_closed = 1'b1;
          end else if (b == dotf_pkg::TAG_PAD) begin
            if (!hit_valid && tag_sel == dotf_pkg::TAG_PAD) take_match(r, off + 9'd1, 8'd0);
          end else begin
            opt_tag = b;
            ph = dotf_pkg::PH_LEN;
          end
        end else if (ph == dotf_pkg::PH_LEN) begin
          hit = !hit_valid && opt_tag == tag_sel;
          if (b == 8'd0) begin
            if (hit) take_match(r, off + 9'd1, 8'd0);
            ph = dotf_pkg::PH_TAG;
          end else begin
            // Hold the candidate until its data is complete inside the region.
            if (hit) begin
              cand_pending = 1'b1;
              hit_offset = off + 9'd1;
              hit_length = b;
            end
            skip_left = b;
            ph = dotf_pkg::PH_FIRST;
          end
        end else begin
          if (ph == dotf_pkg::PH_FIRST && opt_tag == dotf_pkg::TAG_OVERLOAD &&
              r == dotf_pkg::RGN_OPTIONS)
            overload_en = overload_en | b[1:0];
          skip_left = skip_left - 8'd1;
          if (skip_left == 8'd0) begin
            if (cand_pending) begin
              hit_valid = 1'b1;
              hit_region = r;
              cand_pending = 1'b0;
            end
            ph = dotf_pkg::PH_TAG;
          end else begin
            ph = dotf_pkg::PH_DATA;
          end
        end
      end
    end
    if (region_off < dotf_pkg::OFFSET_MAX) region_off = region_off + 9'd1;
    if (it.last_of_message) begin
      res = '0;
      if (hit_valid && cookie_good && cookie_seen == dotf_pkg::COOKIE_LEN) begin
        res.found = 1'b1;
        res.found_region = hit_region - 2'd1;
        res.data_offset = hit_offset;
        res.data_length = hit_length;
      end
      expected_results.push_back(res);
      clear_search_state();
    end
  endfunction

  task automatic send_byte(input dotf_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    track_byte(it);
  endtask

  task automatic send_message();
    msg_bytes[msg_bytes.size() - 1].last_of_message = 1'b1;
    foreach (msg_bytes[i]) send_byte(msg_bytes[i]);
    msg_bytes.delete();
  endtask

  // Drain the block before touching the register.
  task automatic set_search_tag(input logic [7:0] v);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tag_sel = v;
  endtask

  function automatic void add_byte(input logic [7:0] b, input logic [1:0] r);
    dotf_pkg::in_item_t it;
    it.data_byte = b;
    it.region = r;
    it.last_of_message = 1'b0;
    msg_bytes.push_back(it);
  endfunction

  function automatic void add_option(input logic [7:0] t, input logic [7:0] len,
                                     input logic [1:0] r);
    add_byte(t, r);
    if (t != dotf_pkg::TAG_PAD && t != dotf_pkg::TAG_END) begin
      add_byte(len, r);
      repeat (len) add_byte(8'($urandom_range(0, 255)), r);
    end
  endfunction

  // Cookie shapes: good, short, long, one corrupted byte, absent.
  function automatic void add_cookie(input int shape);
    int bad_pos;
    bad_pos = $urandom_range(0, 3);
    if (shape == 4) return;
    for (int i = 0; i < 4; i++) begin
      if (shape == 1 && i == 3) break;
      if (shape == 3 && i == bad_pos)
        add_byte(COOKIE_WORD[31 - 8*i -: 8] ^ 8'($urandom_range(1, 255)),
                 dotf_pkg::RGN_COOKIE);
      else
        add_byte(COOKIE_WORD[31 - 8*i -: 8], dotf_pkg::RGN_COOKIE);
    end
    if (shape == 2) add_byte(8'($urandom_range(0, 255)), dotf_pkg::RGN_COOKIE);
  endfunction

  function automatic logic [7:0] pick_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return tag_sel;
    if (r < 45) return dotf_pkg::TAG_OVERLOAD;
    if (r < 58) return dotf_pkg::TAG_PAD;
    if (r < 63) return dotf_pkg::TAG_END;
    return 8'($urandom_range(1, 254));
  endfunction

  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(0, 4));
    if (r < 95) return 8'($urandom_range(5, 16));
    return 8'($urandom_range(17, 255));
  endfunction

  // Fill close to the region size limit, then run options across it.
  function automatic void add_long_region(input logic [1:0] r);
    int fill;
    int len;
    logic [7:0] filler;
    fill = $urandom_range(296, 311);
    filler = (tag_sel == 8'd1) ? 8'd2 : 8'd1;
    while (fill >= 2) begin
      len = $urandom_range(0, (fill - 2 < 255) ? fill - 2 : 255);
      add_option(filler, 8'(len), r);
      fill -= len + 2;
    end
    if (fill == 1) add_byte(dotf_pkg::TAG_PAD, r);
    repeat ($urandom_range(1, 3)) add_option(pick_tag(), 8'($urandom_range(0, 3)), r);
    repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)), r);
  endfunction

  function automatic void add_region(input logic [1:0] r);
    logic [7:0] t;
    logic [7:0] len;
    if ($urandom_range(0, 99) < 3) begin
      add_long_region(r);
      return;
    end
    repeat ($urandom_range(0, 5)) add_option(pick_tag(), pick_len(), r);
    // Cut the final option short at the region end.
    if ($urandom_range(0, 4) == 0) begin
      t = (tag_sel != dotf_pkg::TAG_PAD && tag_sel != dotf_pkg::TAG_END &&
           $urandom_range(0, 1)) ? tag_sel : 8'($urandom_range(1, 254));
      add_byte(t, r);
      if ($urandom_range(0, 2) != 0) begin
        len = 8'($urandom_range(1, 20));
        add_byte(len, r);
        repeat ($urandom_range(0, len - 1)) add_byte(8'($urandom_range(0, 255)), r);
      end
    end
  endfunction

  function automatic void build_message();
    int n;
    int order;
    logic [1:0] r;
    if ($urandom_range(0, 99) < 12) begin
      n = $urandom_range(1, 30);
      r = 2'($urandom_range(0, 3));
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) r = 2'($urandom_range(0, 3));
        add_byte(8'($urandom_range(0, 255)), r);
      end
    end else begin
      add_cookie(($urandom_range(0, 99) < 80) ? 0 : $urandom_range(1, 4));
      add_region(dotf_pkg::RGN_OPTIONS);
      order = $urandom_range(0, 99);
      if (order < 50) begin
        add_region(dotf_pkg::RGN_FILE);
        add_region(dotf_pkg::RGN_SNAME);
      end else if (order < 60) begin
        add_region(dotf_pkg::RGN_SNAME);
        add_region(dotf_pkg::RGN_FILE);
      end else if (order < 75) begin
        add_region(dotf_pkg::RGN_FILE);
      end else if (order < 85) begin
        add_region(dotf_pkg::RGN_SNAME);
      end
      n = $urandom_range(0, 99);
      if (n < 5) add_region(dotf_pkg::RGN_OPTIONS);
      else if (n < 8) add_byte(COOKIE_WORD[7:0], dotf_pkg::RGN_COOKIE);
    end
    if (msg_bytes.size() == 0)
      add_byte(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
  endfunction

  task automatic test_pad_default();
    add_cookie(0);
    add_byte(dotf_pkg::TAG_PAD, dotf_pkg::RGN_OPTIONS);
    add_byte(dotf_pkg::TAG_END, dotf_pkg::RGN_OPTIONS);
    send_message();
  endtask

  task automatic test_end_tag();
    set_search_tag(dotf_pkg::TAG_END);
    add_cookie(0);
    add_option(8'd7, 8'd0, dotf_pkg::RGN_OPTIONS);
    add_byte(dotf_pkg::TAG_END, dotf_pkg::RGN_OPTIONS);
    send_message();
  endtask

  task automatic test_overload();
    set_search_tag(8'd9);
    add_cookie(0);
    add_option(dotf_pkg::TAG_OVERLOAD, 8'd1, dotf_pkg::RGN_OPTIONS);
    msg_bytes[msg_bytes.size() - 1].data_byte = 8'h03;
    add_option(8'd1, 8'd0, dotf_pkg::RGN_FILE);
    add_byte(dotf_pkg::TAG_END, dotf_pkg::RGN_FILE);
    add_option(8'd9, 8'd1, dotf_pkg::RGN_SNAME);
    send_message();
  endtask

  task automatic test_bad_cookie();
    add_cookie(3);
    add_option(8'd9, 8'd0, dotf_pkg::RGN_OPTIONS);
    send_message();
  endtask

  task automatic test_random_messages();
    logic [7:0] v;
    int phase_end;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: v = 8'd1;
        1: v = dotf_pkg::TAG_PAD;
        2: v = dotf_pkg::TAG_END;
        3: v = dotf_pkg::TAG_OVERLOAD;
        default: v = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) :
                                            8'($urandom_range(1, 5));
      endcase
      set_search_tag(v);
      phase_end = bytes_sent + 100;
      while (bytes_sent < phase_end) begin
        idle_on = ($urandom_range(0, 9) != 0);
        build_message();
        send_message();
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    idle_on = 1'b1;
    bytes_sent = 0;
    mismatches = 0;
    cycle_count = 0;
    tag_sel = dotf_pkg::TAG_PAD;
    clear_search_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pad_default();
    test_end_tag();
    test_overload();
    test_bad_cookie();
    test_random_messages();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
